@@ sv/spfp_pkg.sv @@
// ----------------------------------------------------------------------------
// spfp_pkg: shared types and constants of the station packet field parser
// Holds the queue entry format, the result kind codes and the field length
// decoder for the code-tagged fields of a station reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spfp_pkg;

   // Depth of the queue between front and back.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [7:0] HEADER_BYTE = 8'hFF;

   // Byte position saturates here; fields start at this index.
   localparam logic [2:0] FIELD_START = 3'd5;
   localparam logic [2:0] SUM_START   = 3'd2;

   // Result kinds.
   localparam logic [2:0] KIND_FIELD     = 3'd0;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd1;
   localparam logic [2:0] KIND_HDR_ERR   = 3'd2;
   localparam logic [2:0] KIND_SUM_GOOD  = 3'd3;
   localparam logic [2:0] KIND_SUM_BAD   = 3'd4;
   localparam logic [2:0] KIND_TRUNCATED = 3'd5;

   // Signed temperature codes.
   localparam logic [7:0] CODE_TEMP_IN  = 8'h01;
   localparam logic [7:0] CODE_TEMP_OUT = 8'h02;

   // What the back end does with a queued byte.
   typedef enum logic [1:0] {
      OP_SUM   = 2'd0,
      OP_PARSE = 2'd1,
      OP_LAST  = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       hdr_err;    // verdict must be header error
      logic       too_short;  // packet ended inside the header
   } item_type;

   // Number of value bytes that follow a code; zero for an unknown code.
   function automatic logic [2:0] field_length(input logic [7:0] code);
      logic [2:0] len;
      unique case (code) inside
         8'h06, 8'h07, 8'h17:         len = 3'd1;
         8'h12, 8'h13, 8'h15, 8'h6C:  len = 3'd4;
         8'h01, 8'h02, [8'h08:8'h11],
         8'h16, 8'h19:                len = 3'd2;
         default:                     len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ sv/spfp_front.sv @@
// ----------------------------------------------------------------------------
// spfp_front: byte intake and classification
// Tracks the header position and header failure and tags each byte with the
// work the back end has to do; bytes with no effect are dropped here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        rx_byte,
   input  wire logic              last_byte,
   output spfp_pkg::item_type     push_item,
   output logic                   push
);

   logic [2:0] pos_ff, pos_in;
   logic       hdr_fail_ff, hdr_fail_in;
   logic       in_header;
   logic       not_ff_byte;

   assign in_header   = (pos_ff < spfp_pkg::SUM_START);
   assign not_ff_byte = (rx_byte != spfp_pkg::HEADER_BYTE);

   always_comb begin
      pos_in      = pos_ff;
      hdr_fail_in = hdr_fail_ff;
      push        = 1'b0;
      push_item.data      = rx_byte;
      push_item.hdr_err   = hdr_fail_ff | (in_header & not_ff_byte);
      push_item.too_short = in_header;
      push_item.op        = spfp_pkg::OP_SUM;
      if (accept) begin
         if (last_byte) begin
            push         = 1'b1;
            push_item.op = spfp_pkg::OP_LAST;
            pos_in       = 3'd0;
            hdr_fail_in  = 1'b0;
         end else begin
            if (pos_ff < spfp_pkg::FIELD_START) begin
               pos_in = pos_ff + 3'd1;
            end
            if (!hdr_fail_ff) begin
               if (in_header) begin
                  if (not_ff_byte) begin
                     hdr_fail_in = 1'b1;
                  end
               end else begin
                  push         = 1'b1;
                  push_item.op = (pos_ff < spfp_pkg::FIELD_START) ?
                                 spfp_pkg::OP_SUM : spfp_pkg::OP_PARSE;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= 3'd0;
         hdr_fail_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         hdr_fail_ff <= hdr_fail_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/spfp_queue.sv @@
// ----------------------------------------------------------------------------
// spfp_queue: short queue between front and back
// A small circular buffer of classified items; full stops the intake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire spfp_pkg::item_type push_item,
   input  wire logic              pop,
   output spfp_pkg::item_type     head_item,
   output logic                   not_empty,
   output logic                   full
);

   spfp_pkg::item_type entries_ff [spfp_pkg::QueueDepth];

   logic [spfp_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [spfp_pkg::QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [spfp_pkg::QueueCntW-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == spfp_pkg::QueueCntW'(spfp_pkg::QueueDepth));
   assign head_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + spfp_pkg::QueuePtrW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + spfp_pkg::QueuePtrW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + spfp_pkg::QueueCntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - spfp_pkg::QueueCntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ sv/spfp_back.sv @@
// ----------------------------------------------------------------------------
// spfp_back: checksum, field decode and result register
// Keeps the running sum and the field assembly state and drives the result
// register that the output channel reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfp_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire spfp_pkg::item_type  head_item,
   input  wire logic                not_empty,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic [2:0]               rsp_kind,
   output logic [7:0]               rsp_field_code,
   output logic signed [32:0]       rsp_field_value,
   output logic [7:0]               rsp_computed_sum
);

   logic [7:0]  sum_ff, sum_in;
   logic        phase_ff, phase_in;      // 1 while value bytes are owed
   logic [7:0]  code_ff, code_in;
   logic [2:0]  remain_ff, remain_in;
   logic [31:0] acc_ff, acc_in;

   logic               valid_ff, valid_in;
   logic [2:0]         kind_ff, kind_in;
   logic [7:0]         fcode_ff, fcode_in;
   logic signed [32:0] value_ff, value_in;
   logic [7:0]         csum_ff, csum_in;

   logic        emit;
   logic [2:0]  len;
   logic [31:0] acc_next;
   logic        signed_code;
   logic [7:0]  b;

   assign b           = head_item.data;
   assign pop         = not_empty & (~valid_ff | ~rsp_stall);
   assign len         = spfp_pkg::field_length(b);
   assign acc_next    = {acc_ff[23:0], b};
   assign signed_code = (code_ff == spfp_pkg::CODE_TEMP_IN) |
                        (code_ff == spfp_pkg::CODE_TEMP_OUT);

   always_comb begin
      sum_in    = sum_ff;
      phase_in  = phase_ff;
      code_in   = code_ff;
      remain_in = remain_ff;
      acc_in    = acc_ff;
      emit      = 1'b0;
      kind_in   = kind_ff;
      fcode_in  = fcode_ff;
      value_in  = value_ff;
      csum_in   = csum_ff;
      if (pop) begin
         unique case (head_item.op)
            spfp_pkg::OP_LAST: begin
               emit     = 1'b1;
               fcode_in = 8'd0;
               value_in = {25'd0, b};
               csum_in  = sum_ff;
               if (head_item.hdr_err) begin
                  kind_in = spfp_pkg::KIND_HDR_ERR;
               end else if (head_item.too_short || phase_ff) begin
                  kind_in = spfp_pkg::KIND_TRUNCATED;
               end else if (sum_ff == b) begin
                  kind_in = spfp_pkg::KIND_SUM_GOOD;
               end else begin
                  kind_in = spfp_pkg::KIND_SUM_BAD;
               end
               sum_in    = 8'd0;
               phase_in  = 1'b0;
               code_in   = 8'd0;
               remain_in = 3'd0;
               acc_in    = 32'd0;
            end
            spfp_pkg::OP_SUM: begin
               sum_in = sum_ff + b;
            end
            spfp_pkg::OP_PARSE: begin
               sum_in = sum_ff + b;
               if (!phase_ff) begin
                  if (len == 3'd0) begin
                     emit     = 1'b1;
                     kind_in  = spfp_pkg::KIND_UNKNOWN;
                     fcode_in = b;
                     value_in = 33'sd0;
                     csum_in  = 8'd0;
                  end else begin
                     code_in   = b;
                     remain_in = len;
                     acc_in    = 32'd0;
                     phase_in  = 1'b1;
                  end
               end else begin
                  acc_in    = acc_next;
                  remain_in = remain_ff - 3'd1;
                  if (remain_ff == 3'd1) begin
                     emit     = 1'b1;
                     phase_in = 1'b0;
                     kind_in  = spfp_pkg::KIND_FIELD;
                     fcode_in = code_ff;
                     csum_in  = 8'd0;
                     // Temperatures are 16-bit two's complement.
                     if (signed_code) begin
                        value_in = {{17{acc_next[15]}}, acc_next[15:0]};
                     end else begin
                        value_in = {1'b0, acc_next};
                     end
                  end
               end
            end
            default: begin
               sum_in = sum_ff;
            end
         endcase
      end
      valid_in = emit | (valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff    <= 8'd0;
         phase_ff  <= 1'b0;
         code_ff   <= 8'd0;
         remain_ff <= 3'd0;
         acc_ff    <= 32'd0;
         valid_ff  <= 1'b0;
      end else begin
         sum_ff    <= sum_in;
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         remain_ff <= remain_in;
         acc_ff    <= acc_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      fcode_ff <= fcode_in;
      value_ff <= value_in;
      csum_ff  <= csum_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_field_code   = fcode_ff;
   assign rsp_field_value  = value_ff;
   assign rsp_computed_sum = csum_ff;

endmodule

`default_nettype wire

@@ sv/station_packet_field_parser.sv @@
// ----------------------------------------------------------------------------
// station_packet_field_parser: weather-station reply byte parser
// Checks the header, keeps the checksum and decodes code-tagged fields of a
// reply that arrives one byte per item, ending each packet with a verdict.
// ----------------------------------------------------------------------------
// The block takes one reply byte per item on the req_ channel, with
// req_last_byte marking the checksum byte that closes a packet. Fields are
// reported on the rsp_ channel as soon as their last value byte arrives,
// before the checksum is known, so a user must hold them until the verdict
// item (header error, sum good, sum bad or truncated) that ends every packet.
// Throughput is one byte per clock cycle while req_stall is low: the front
// classifies a byte in the cycle it is accepted, a four-item queue carries
// it to the back, and the back updates the sum and field state and loads
// the result register. The byte that completes a result passes through a
// queue entry and then the result register before the result appears on
// the rsp_ channel. While rsp_stall is held over a waiting result, the
// back stops popping, so the queue fills and then req_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module station_packet_field_parser (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic          req_last_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [2:0]         rsp_kind,
   output logic [7:0]         rsp_field_code,
   output logic signed [32:0] rsp_field_value,
   output logic [7:0]         rsp_computed_sum
);

   // Front to queue: a classified item and its write strobe.
   spfp_pkg::item_type push_item;
   logic               push;

   // Queue to back: the oldest item and the queue status.
   spfp_pkg::item_type head_item;
   logic               not_empty;
   logic               full;
   logic               pop;

   logic               accept;

   // The intake stops only when the queue has no free slot.
   assign req_stall = full;
   assign accept    = req_valid & ~full;

   spfp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .last_byte (req_last_byte),
      .push_item (push_item),
      .push      (push)
   );

   spfp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .not_empty (not_empty),
      .full      (full)
   );

   // The back pops an item whenever its result register is free or being taken.
   spfp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_item        (head_item),
      .not_empty        (not_empty),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_field_code   (rsp_field_code),
      .rsp_field_value  (rsp_field_value),
      .rsp_computed_sum (rsp_computed_sum)
   );

endmodule

`default_nettype wire
